>>> hdl/plx_pkg.sv
// Shared types, token codes and byte constants for the punctuation lexer.
// No dependencies; used by plx_front, plx_back and the top level.
package plx_pkg;

  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_COLON  = 2'd1,
    PEND_EXCLAM = 2'd2,
    PEND_EQUAL  = 2'd3
  } pend_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_EMIT  = 3'd1,
    OP_OPEN  = 3'd2,
    OP_CLOSE = 3'd3,
    OP_EOF   = 3'd4
  } op_e;

  localparam logic [4:0] TK_HASH      = 5'd6;
  localparam logic [4:0] TK_COLON     = 5'd7;
  localparam logic [4:0] TK_COLON2    = 5'd8;
  localparam logic [4:0] TK_COMMA     = 5'd9;
  localparam logic [4:0] TK_DOT       = 5'd10;
  localparam logic [4:0] TK_CARET     = 5'd11;
  localparam logic [4:0] TK_EXCLAM    = 5'd12;
  localparam logic [4:0] TK_NOT_EQ    = 5'd13;
  localparam logic [4:0] TK_QUESTION  = 5'd14;
  localparam logic [4:0] TK_EQ        = 5'd15;
  localparam logic [4:0] TK_EQ_EQ     = 5'd16;
  localparam logic [4:0] TK_EOF       = 5'd17;
  localparam logic [4:0] TK_UNHANDLED = 5'd18;

  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_EXCLAM   = 8'h21;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_VTAB     = 8'h0B;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;

  // Opener selector: 0 paren, 1 bracket, 2 brace.
  localparam logic [1:0] SEL_PAREN   = 2'd0;
  localparam logic [1:0] SEL_BRACKET = 2'd1;
  localparam logic [1:0] SEL_BRACE   = 2'd2;

  // Work item from front to back.
  typedef struct packed {
    pend_e      pend;   // single-byte token to flush first
    op_e        op;
    logic [1:0] sel;    // opener selector for open/close
    logic [4:0] kind;   // token kind for plain emits
    logic [7:0] raw;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [4:0] kind;
    logic       fake;
    logic [7:0] raw;
    logic       ovf;
    logic       last;
  } res_t;

  function automatic logic [4:0] pend_kind(pend_e p);
    logic [4:0] k;
    case (p)
      PEND_COLON:  k = TK_COLON;
      PEND_EXCLAM: k = TK_EXCLAM;
      PEND_EQUAL:  k = TK_EQ;
      default:     k = 5'd0;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] pend_byte(pend_e p);
    logic [7:0] b;
    case (p)
      PEND_COLON:  b = CH_COLON;
      PEND_EXCLAM: b = CH_EXCLAM;
      PEND_EQUAL:  b = CH_EQUAL;
      default:     b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/plx_fifo.sv
// Small synchronous queue used between front and back and on the result side.
// No package dependencies.
module plx_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/plx_front.sv
// Front end: classifies each source byte, resolves two-byte tokens through
// the pending register and issues work items. Depends on plx_pkg.
module plx_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          req_type_i,
  input  logic [7:0]    char_code_i,
  output logic          cmd_v_o,
  output plx_pkg::cmd_t cmd_o
);
  import plx_pkg::*;

  pend_e      pend_q, pend_d;
  logic [7:0] prev_q, prev_d;
  cmd_t       cmd;
  logic       paired;

  always_comb begin
    cmd      = '0;
    cmd.pend = PEND_NONE;
    cmd.op   = OP_NONE;
    cmd.raw  = char_code_i;
    pend_d   = pend_q;
    prev_d   = prev_q;
    paired   = 1'b0;
    if (req_type_i) begin
      cmd.pend = pend_q;
      cmd.op   = OP_EOF;
      cmd.raw  = prev_q;
      pend_d   = PEND_NONE;
      prev_d   = '0;
    end else begin
      prev_d = char_code_i;
      if (pend_q == PEND_COLON && char_code_i == CH_COLON) begin
        cmd.op   = OP_EMIT;
        cmd.kind = TK_COLON2;
        cmd.raw  = CH_COLON;
        paired   = 1'b1;
      end else if (pend_q == PEND_EXCLAM && char_code_i == CH_EQUAL) begin
        cmd.op   = OP_EMIT;
        cmd.kind = TK_NOT_EQ;
        cmd.raw  = CH_EXCLAM;
        paired   = 1'b1;
      end else if (pend_q == PEND_EQUAL && char_code_i == CH_EQUAL) begin
        cmd.op   = OP_EMIT;
        cmd.kind = TK_EQ_EQ;
        cmd.raw  = CH_EQUAL;
        paired   = 1'b1;
      end
      if (paired) begin
        pend_d = PEND_NONE;
      end else begin
        // flush whatever was pending ahead of this byte
        cmd.pend = pend_q;
        pend_d   = PEND_NONE;
        case (char_code_i)
          CH_SPACE, CH_TAB, CH_VTAB, CH_CR, CH_LF: cmd.op = OP_NONE;
          CH_LPAREN:   begin cmd.op = OP_OPEN;  cmd.sel = SEL_PAREN;   end
          CH_LBRACKET: begin cmd.op = OP_OPEN;  cmd.sel = SEL_BRACKET; end
          CH_LBRACE:   begin cmd.op = OP_OPEN;  cmd.sel = SEL_BRACE;   end
          CH_RPAREN:   begin cmd.op = OP_CLOSE; cmd.sel = SEL_PAREN;   end
          CH_RBRACKET: begin cmd.op = OP_CLOSE; cmd.sel = SEL_BRACKET; end
          CH_RBRACE:   begin cmd.op = OP_CLOSE; cmd.sel = SEL_BRACE;   end
          CH_HASH:     begin cmd.op = OP_EMIT;  cmd.kind = TK_HASH;     end
          CH_COMMA:    begin cmd.op = OP_EMIT;  cmd.kind = TK_COMMA;    end
          CH_DOT:      begin cmd.op = OP_EMIT;  cmd.kind = TK_DOT;      end
          CH_CARET:    begin cmd.op = OP_EMIT;  cmd.kind = TK_CARET;    end
          CH_QUESTION: begin cmd.op = OP_EMIT;  cmd.kind = TK_QUESTION; end
          CH_COLON:    pend_d = PEND_COLON;
          CH_EXCLAM:   pend_d = PEND_EXCLAM;
          CH_EQUAL:    pend_d = PEND_EQUAL;
          default:     begin cmd.op = OP_EMIT;  cmd.kind = TK_UNHANDLED; end
        endcase
      end
    end
  end

  // Drop items that produce no word.
  assign cmd_v_o = push_i && (cmd.op != OP_NONE || cmd.pend != PEND_NONE);
  assign cmd_o   = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
      prev_q <= '0;
    end else if (push_i) begin
      pend_q <= pend_d;
      prev_q <= prev_d;
    end
  end

endmodule

>>> hdl/plx_back.sv
// Back end: executes work items against the opener stack memory and emits
// result words, including fake closers during repair. Depends on plx_pkg.
module plx_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  plx_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output plx_pkg::res_t res_o
);
  import plx_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_RUN   = 3'b001,
    S_POP   = 3'b010,
    S_FINAL = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_m1;
  logic          pend_done_q, pend_done_d;
  logic          top_vld_q;
  logic [1:0]    stack_mem [STACK_DEPTH];
  logic [1:0]    rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic          stk_room;
  logic [4:0]    final_kind;
  res_t          res;
  logic          res_push, cmd_pop;

  assign cnt_m1     = cnt_q - CW'(1);
  assign rd_addr    = cnt_m1[AW-1:0];
  assign wr_addr    = cnt_q[AW-1:0];
  assign stk_room   = (cnt_q < CW'(STACK_DEPTH));
  assign final_kind = (cmd_i.op == OP_EOF) ? TK_EOF : {2'b00, cmd_i.sel, 1'b1};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_done_d = pend_done_q;
    wr_en       = 1'b0;
    res_push    = 1'b0;
    cmd_pop     = 1'b0;
    res         = '0;
    res.raw     = cmd_i.raw;
    case (state_q)
      S_RUN: begin
        if (!cmd_empty_i) begin
          if (cmd_i.pend != PEND_NONE && !pend_done_q) begin
            res.kind = pend_kind(cmd_i.pend);
            res.raw  = pend_byte(cmd_i.pend);
            res.last = (cmd_i.op == OP_NONE);
            if (!res_full_i) begin
              res_push = 1'b1;
              if (cmd_i.op == OP_NONE) begin
                cmd_pop = 1'b1;
              end else begin
                pend_done_d = 1'b1;
              end
            end
          end else begin
            case (cmd_i.op)
              OP_EMIT: begin
                res.kind = cmd_i.kind;
                res.last = 1'b1;
                if (!res_full_i) begin
                  res_push    = 1'b1;
                  cmd_pop     = 1'b1;
                  pend_done_d = 1'b0;
                end
              end
              OP_OPEN: begin
                res.kind = {2'b00, cmd_i.sel, 1'b0};
                res.ovf  = !stk_room;
                res.last = 1'b1;
                if (!res_full_i) begin
                  res_push    = 1'b1;
                  cmd_pop     = 1'b1;
                  pend_done_d = 1'b0;
                  if (stk_room) begin
                    wr_en = 1'b1;
                    cnt_d = cnt_q + CW'(1);
                  end
                end
              end
              OP_CLOSE, OP_EOF: state_d = S_POP;
              default: begin
                cmd_pop     = 1'b1;
                pend_done_d = 1'b0;
              end
            endcase
          end
        end
      end
      S_POP: begin
        if (cnt_q == '0) begin
          state_d = S_FINAL;
        end else if (top_vld_q) begin
          if (cmd_i.op == OP_CLOSE && rd_q == cmd_i.sel) begin
            cnt_d   = cnt_m1;
            state_d = S_FINAL;
          end else begin
            // unmatched opener: close it with a fake word
            res.kind = {2'b00, rd_q, 1'b1};
            res.fake = 1'b1;
            if (!res_full_i) begin
              res_push = 1'b1;
              cnt_d    = cnt_m1;
            end
          end
        end
      end
      S_FINAL: begin
        res.kind = final_kind;
        res.last = 1'b1;
        if (!res_full_i) begin
          res_push    = 1'b1;
          cmd_pop     = 1'b1;
          pend_done_d = 1'b0;
          state_d     = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  assign res_push_o = res_push;
  assign cmd_pop_o  = cmd_pop;
  assign res_o      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      cnt_q       <= '0;
      pend_done_q <= 1'b0;
      top_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_done_q <= pend_done_d;
      // top read is good in the cycle after the depth settles
      top_vld_q   <= (cnt_d == cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= cmd_i.sel;
    end
    rd_q <= stack_mem[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack depth beyond limit");

  a_pop_needs_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP && cnt_d != cnt_q) |-> top_vld_q)
    else $error("pop taken on stale stack read");

  a_last_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res.last) |-> cmd_pop)
    else $error("last word sent without retiring the item");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && cmd_i.op == OP_EOF && res_push) |=> (cnt_q == '0))
    else $error("stack not empty after end of source");

endmodule

>>> hdl/punct_lexer_with_delimiter_repair.sv
// Punctuation lexer with delimiter repair: push one source byte or an
// end-of-source marker per word and pop token words. The front takes a byte
// every cycle while its two-entry work queue has room; the back retires a
// plain token or a pending-flush without waiting on the opener stack, so
// ordinary text runs at one byte per cycle while the result queue has room.
// A closer or end of source holds the back while a pending byte is flushed,
// each unmatched opener gets a fake closer and then the final word is sent;
// each fake closer waits on the registered read port of the opener stack
// memory (a read is good in the cycle after the depth settles).
// Depends on plx_pkg, plx_fifo, plx_front and plx_back.
module punct_lexer_with_delimiter_repair #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       req_type_i,
  input  logic [7:0] char_code_i,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] token_kind_o,
  output logic       is_fake_o,
  output logic [7:0] raw_char_o,
  output logic       overflow_o,
  output logic       last_of_run_o
);
  import plx_pkg::*;

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned RES_W = $bits(res_t);

  logic             accept;
  logic             cmd_v, cmd_empty, cmd_pop;
  cmd_t             cmd_in, cmd_head;
  logic [CMD_W-1:0] cmd_head_bits;
  logic             res_push, res_full;
  res_t             res_in, res_head;
  logic [RES_W-1:0] res_head_bits;

  assign accept = push && !full;

  plx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .cmd_v_o     (cmd_v),
    .cmd_o       (cmd_in)
  );

  plx_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_v),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head_bits),
    .empty_o (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_head_bits);

  plx_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  plx_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head_bits),
    .empty_o (empty)
  );

  assign res_head      = res_t'(res_head_bits);
  assign token_kind_o  = res_head.kind;
  assign is_fake_o     = res_head.fake;
  assign raw_char_o    = res_head.raw;
  assign overflow_o    = res_head.ovf;
  assign last_of_run_o = res_head.last;

endmodule
